>>> rtl/core/tpts_pkg.sv
// Package for the tick periodic task scheduler: sizes, opcodes, status codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
package tpts_pkg;

  localparam int TASKS      = 8;
  localparam int COUNT_BITS = 16;
  localparam int IDX_BITS   = $clog2(TASKS);
  localparam int OFF_BITS   = IDX_BITS;

  typedef enum logic [2:0] {
    OP_CLEAR    = 3'd0,
    OP_ADD      = 3'd1,
    OP_START    = 3'd2,
    OP_STOP     = 3'd3,
    OP_TICK     = 3'd4,
    OP_DISPATCH = 3'd5,
    OP_WAIT     = 3'd6,
    OP_RSTWAIT  = 3'd7
  } op_t;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_PENDING = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_GSCAN,
    S_GMOD,
    S_STAGGER,
    S_OUT
  } state_t;

  typedef struct packed {
    logic exec;       // perform the simple operation held in the item register
    logic gcd_init;   // clear scan index and gcd accumulator
    logic gcd_scan;   // fold the current slot into the gcd accumulator
    logic gcd_step;   // one subtractive step of the running gcd
    logic stagger;    // apply offsets when qualified, then set run flag
  } tpts_cmd_t;

  typedef struct packed {
    logic scan_done;  // all slots folded
    logic mod_done;   // subtractive loop finished
  } tpts_sts_t;

endpackage

>>> rtl/core/tpts_ctrl.sv
// Controller state machine for the scheduler.
// Depends on tpts_pkg.
module tpts_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  tpts_pkg::op_t       op,
  input  tpts_pkg::tpts_sts_t sts,
  input  logic                out_tready,
  output logic                in_tready,
  output logic                out_tvalid,
  output tpts_pkg::tpts_cmd_t cmd
);

  tpts_pkg::state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tpts_pkg::S_IDLE:    if (in_fire) state_nxt = tpts_pkg::S_EXEC;
      tpts_pkg::S_EXEC: begin
        if (op == tpts_pkg::OP_START) state_nxt = tpts_pkg::S_GSCAN;
        else state_nxt = tpts_pkg::S_OUT;
      end
      tpts_pkg::S_GSCAN: begin
        if (sts.scan_done) state_nxt = tpts_pkg::S_STAGGER;
        else state_nxt = tpts_pkg::S_GMOD;
      end
      tpts_pkg::S_GMOD:    if (sts.mod_done) state_nxt = tpts_pkg::S_GSCAN;
      tpts_pkg::S_STAGGER: state_nxt = tpts_pkg::S_OUT;
      tpts_pkg::S_OUT:     if (out_tready) state_nxt = tpts_pkg::S_IDLE;
      default:             state_nxt = tpts_pkg::S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    case (state_r)
      tpts_pkg::S_IDLE:    in_tready = 1'b1;
      tpts_pkg::S_EXEC: begin
        cmd.exec     = (op != tpts_pkg::OP_START);
        cmd.gcd_init = (op == tpts_pkg::OP_START);
      end
      tpts_pkg::S_GSCAN:   cmd.gcd_scan = !sts.scan_done;
      tpts_pkg::S_GMOD:    cmd.gcd_step = 1'b1;
      tpts_pkg::S_STAGGER: cmd.stagger = 1'b1;
      tpts_pkg::S_OUT:     out_tvalid = 1'b1;
      default:             ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= tpts_pkg::S_IDLE;
    else state_r <= state_nxt;
  end

  a_exec_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == tpts_pkg::S_EXEC) else $error("no exec after accept");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != tpts_pkg::S_IDLE |-> !in_tready) else $error("ready while busy");
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd)) else $error("multiple commands");

endmodule

>>> rtl/core/tpts_dp.sv
// Datapath: slot table, counters, delay slots, gcd unit and result register.
// Depends on tpts_pkg.
module tpts_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_fire,
  input  logic [2:0]                 in_op,
  input  logic                       in_priority_high,
  input  logic [15:0]                in_task_period,
  input  logic [2:0]                 in_delay_index,
  input  logic [15:0]                in_delay_ticks,
  input  tpts_pkg::tpts_cmd_t        cmd,
  output tpts_pkg::tpts_sts_t        sts,
  output tpts_pkg::op_t              op,
  output logic [1:0]                 status,
  output logic [2:0]                 slot,
  output logic [7:0]                 ready_mask,
  output logic                       running
);

  localparam int CB = tpts_pkg::COUNT_BITS;
  localparam int NT = tpts_pkg::TASKS;
  localparam int IB = tpts_pkg::IDX_BITS;

  // captured item
  tpts_pkg::op_t   op_r;
  logic            hi_r;
  logic [CB-1:0]   per_r, dt_r;
  logic [2:0]      di_r;

  // state
  logic [NT-1:0]   used_r, ready_r, dact_r;
  logic [CB-1:0]   reload_r [NT];
  logic [CB-1:0]   count_r  [NT];
  logic [CB-1:0]   dcnt_r   [NT];
  logic [tpts_pkg::OFF_BITS-1:0] off_r [NT];
  logic            run_r;

  // gcd unit
  logic [IB:0]     scan_r;
  logic [CB-1:0]   ga_r, gb_r;
  logic            gzero_r, gfirst_r;
  logic [IB:0]     n_r;

  // result
  logic [1:0]      status_r;
  logic [2:0]      slot_r;
  logic [7:0]      mask_r;

  assign op         = op_r;
  assign status     = status_r;
  assign slot       = slot_r;
  assign ready_mask = mask_r;
  assign running    = run_r;

  assign sts.scan_done = (scan_r == (IB+1)'(NT));
  assign sts.mod_done  = (gb_r == '0);

  logic [IB-1:0] scan_idx;
  assign scan_idx = scan_r[IB-1:0];

  // number of used slots below index i
  function automatic logic [IB:0] cnt_below(input int i);
    logic [IB:0] c;
    c = '0;
    for (int j = 0; j < NT; j++) if (j < i && used_r[j]) c = c + 1'b1;
    return c;
  endfunction

  // free slot search
  logic          found;
  logic [IB-1:0] free_idx;
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = 0; i < NT; i++) begin
      if (hi_r) begin
        if (!found && !used_r[i]) begin
          found    = 1'b1;
          free_idx = IB'(i);
        end
      end else if (!found && !used_r[NT-1-i]) begin
        found    = 1'b1;
        free_idx = IB'(NT-1-i);
      end
    end
  end

  // delay index in range
  logic di_ok;
  logic [IB-1:0] di_idx;
  assign di_ok  = ({29'd0, di_r} < 32'(NT));
  assign di_idx = IB'(di_r);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r  <= tpts_pkg::op_t'(in_op);
      hi_r  <= in_priority_high;
      per_r <= CB'(in_task_period);
      dt_r  <= CB'(in_delay_ticks);
      di_r  <= in_delay_index;
    end
  end

  // main state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      ready_r <= '0;
      dact_r <= '0;
      run_r <= 1'b0;
      for (int i = 0; i < NT; i++) begin
        reload_r[i] <= '0;
        count_r[i]  <= '0;
        dcnt_r[i]   <= '0;
        off_r[i]    <= '0;
      end
    end else begin
      if (cmd.exec) begin
        case (op_r)
          tpts_pkg::OP_CLEAR: begin
            used_r <= '0;
            run_r  <= 1'b0;
          end
          tpts_pkg::OP_ADD: begin
            if (found) begin
              used_r[free_idx]   <= 1'b1;
              reload_r[free_idx] <= per_r;
              count_r[free_idx]  <= per_r;
              ready_r[free_idx]  <= 1'b0;
            end
          end
          tpts_pkg::OP_STOP: run_r <= 1'b0;
          tpts_pkg::OP_TICK: begin
            if (run_r) begin
              for (int i = 0; i < NT; i++) begin
                if (dact_r[i] && dcnt_r[i] != '0) dcnt_r[i] <= dcnt_r[i] - 1'b1;
                if (used_r[i]) begin
                  if (off_r[i] != '0) off_r[i] <= off_r[i] - 1'b1;
                  else if (count_r[i] != '0) begin
                    if (count_r[i] == CB'(1)) begin
                      ready_r[i] <= 1'b1;
                      count_r[i] <= reload_r[i];
                    end else count_r[i] <= count_r[i] - 1'b1;
                  end else if (reload_r[i] == '0) ready_r[i] <= 1'b1;
                end
              end
            end
          end
          tpts_pkg::OP_DISPATCH: begin
            for (int i = 0; i < NT; i++)
              if (used_r[i] && ready_r[i] && reload_r[i] != '0) ready_r[i] <= 1'b0;
          end
          tpts_pkg::OP_WAIT: begin
            if (di_ok) begin
              if (!dact_r[di_idx]) begin
                dcnt_r[di_idx] <= dt_r;
                dact_r[di_idx] <= 1'b1;
              end else if (dcnt_r[di_idx] == '0) dact_r[di_idx] <= 1'b0;
            end
          end
          tpts_pkg::OP_RSTWAIT: if (di_ok) dact_r[di_idx] <= 1'b0;
          default: ;
        endcase
      end
      // staggered offsets then run
      if (cmd.stagger) begin
        if (!gzero_r && ga_r > CB'(1) && n_r > (IB+1)'(1)) begin
          for (int i = 0; i < NT; i++) begin
            if (used_r[i]) off_r[i] <= tpts_pkg::OFF_BITS'(cnt_below(i));
          end
        end
        run_r <= 1'b1;
      end
    end
  end

  // iterative gcd: scan slots, subtractive Euclid one step per cycle
  always_ff @(posedge clk) begin
    if (cmd.gcd_init) begin
      scan_r   <= '0;
      ga_r     <= '0;
      gb_r     <= '0;
      gzero_r  <= 1'b0;
      gfirst_r <= 1'b1;
      n_r      <= '0;
    end else if (cmd.gcd_scan) begin
      scan_r <= scan_r + 1'b1;
      if (used_r[scan_idx]) begin
        n_r <= n_r + 1'b1;
        if (gfirst_r) begin
          ga_r     <= count_r[scan_idx];
          gb_r     <= '0;
          gfirst_r <= 1'b0;
          if (count_r[scan_idx] == '0) gzero_r <= 1'b1;
        end else if (count_r[scan_idx] == '0 || ga_r == '0) begin
          gzero_r <= 1'b1;
          ga_r    <= '0;
          gb_r    <= '0;
        end else gb_r <= count_r[scan_idx];
      end else gb_r <= '0;
    end else if (cmd.gcd_step) begin
      // subtractive step: equal ends the loop with the gcd in a
      if (gb_r != '0) begin
        if (ga_r == gb_r) gb_r <= '0;
        else if (ga_r > gb_r) ga_r <= ga_r - gb_r;
        else begin
          ga_r <= gb_r;
          gb_r <= ga_r;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.exec || cmd.stagger) begin
      status_r <= tpts_pkg::ST_OK;
      slot_r   <= '0;
      mask_r   <= '0;
      if (cmd.exec) begin
        case (op_r)
          tpts_pkg::OP_ADD: begin
            if (found) slot_r <= 3'(free_idx);
            else status_r <= tpts_pkg::ST_FULL;
          end
          tpts_pkg::OP_DISPATCH: begin
            for (int i = 0; i < NT && i < 8; i++)
              mask_r[i] <= used_r[i] & ready_r[i];
          end
          tpts_pkg::OP_WAIT: begin
            if (di_ok && (!dact_r[di_idx] || dcnt_r[di_idx] != '0))
              status_r <= tpts_pkg::ST_PENDING;
          end
          default: ;
        endcase
      end
    end
  end

  a_stagger_runs: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.stagger |=> run_r) else $error("start did not set run");
  a_clear_stops: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && op_r == tpts_pkg::OP_CLEAR |=> !run_r && used_r == '0)
    else $error("clear failed");
  a_add_marks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && op_r == tpts_pkg::OP_ADD && found |=> used_r[$past(free_idx)])
    else $error("add did not mark slot");

endmodule

>>> rtl/core/tick_periodic_task_scheduler.sv
// Tick periodic task scheduler, top level: controller plus datapath.
// An accepted item is executed and its result registered before out_tvalid rises;
// start instead runs a gcd scan over all TASKS slots with subtractive steps, then stagger.
// One item in flight; next accepted the cycle after result taken.
// Reset: synchronous active-low rst_n empties all slots, clears counts, stops.
// Depends on tpts_pkg, tpts_ctrl, tpts_dp.
module tick_periodic_task_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // op[2:0], task_period[18:3], delay_index[21:19],
                                  // delay_ticks[37:22], zero fill
  input  logic        in_tuser,   // priority_high
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // status[1:0], slot[4:2], ready_mask[12:5],
                                  // running[13], zero fill
);

  tpts_pkg::tpts_cmd_t cmd;
  tpts_pkg::tpts_sts_t sts;
  tpts_pkg::op_t       op;
  logic                in_fire;
  logic [1:0]          status;
  logic [2:0]          slot;
  logic [7:0]          ready_mask;
  logic                running;

  assign in_fire   = in_tvalid && in_tready;
  assign out_tdata = {2'b00, running, ready_mask, slot, status};

  tpts_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .op, .sts, .out_tready,
    .in_tready, .out_tvalid, .cmd
  );

  tpts_dp u_dp (
    .clk, .rst_n, .in_fire,
    .in_op            (in_tdata[2:0]),
    .in_priority_high (in_tuser),
    .in_task_period   (in_tdata[18:3]),
    .in_delay_index   (in_tdata[21:19]),
    .in_delay_ticks   (in_tdata[37:22]),
    .cmd, .sts, .op, .status, .slot, .ready_mask, .running
  );

endmodule
